// ----- design/adam_parameter_update_macros.svh -----
// assertion macros for the adam update block
`ifndef ADAM_PARAMETER_UPDATE_MACROS_SVH
`define ADAM_PARAMETER_UPDATE_MACROS_SVH

// a condition implies a consequence on the next edge
`define ADAM_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

// a condition implies a consequence on the same edge
`define ADAM_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

`endif

// ----- design/adam_pkg.sv -----
`timescale 1ns / 1ps
package adam_pkg;

  localparam int FracBits   = 24;
  localparam int CfgWidth   = 32;
  localparam int CfgIdxW    = 2;
  localparam int SqrtStages = 28;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_SCALE   = 2'd0,
    REG_DECAY_FIRST  = 2'd1,
    REG_DECAY_SECOND = 2'd2,
    REG_EPSILON      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient;
    logic signed [31:0] mean_in;
    logic [31:0]        variance_in;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic signed [31:0] mean_out;
    logic [31:0]        variance_out;
    logic               last_out;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] step_scale;
    logic [23:0]        decay_first;
    logic [23:0]        decay_second;
    logic [24:0]        epsilon;
  } cfg_t;

  // pipeline control shared by all stages
  typedef struct packed {
    logic advance;
    logic flush;
  } pipe_ctl_t;

endpackage

// ----- design/adam_parameter_update.sv -----
`timescale 1ns / 1ps
// adam parameter update, Q8.24 fixed point
// input channel in_valid/in_ready carries one word per parameter: weight,
// gradient, first and second moment, last marker. out_valid/out_ready
// returns the updated weight, moments and a copy of the marker.
// config: cfg_we with cfg_index/cfg_data writes step_scale, decay_first,
// decay_second, epsilon; write only while the pipeline is empty.
// throughput: one word per cycle while out_ready keeps the pipeline
// advancing. path from acceptance to out_valid: 4 moment stages, the
// 28-stage square root (one result bit per stage), 2 divisor setup
// stages, the 57-stage restoring divider and 2 scale stages.
// reset clears all valid bits and loads the register defaults.
// when the receiver stalls the whole pipeline holds; in_ready falls only
// if the output word is waiting and nothing is free to move
module adam_parameter_update (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  adam_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output adam_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [adam_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [adam_pkg::CfgWidth-1:0]    cfg_data
);
  import adam_pkg::*;
  `include "adam_parameter_update_macros.svh"

  cfg_t      cfg;
  pipe_ctl_t ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_scale   <= '0;
      cfg.decay_first  <= 24'd15099494;
      cfg.decay_second <= 24'd16760438;
      cfg.epsilon      <= 25'd1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_SCALE:   cfg.step_scale   <= cfg_data;
        REG_DECAY_FIRST:  cfg.decay_first  <= cfg_data[23:0];
        REG_DECAY_SECOND: cfg.decay_second <= cfg_data[23:0];
        REG_EPSILON:      cfg.epsilon      <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // global stall: advance when the output stage is free
  assign ctl.advance = !out_valid || out_ready;
  assign ctl.flush   = 1'b0;
  assign in_ready    = ctl.advance;

  logic               m_v;
  logic signed [31:0] m_mean, m_w;
  logic [31:0]        m_var;
  logic               m_l;

  adam_moments u_mom (
    .clk, .rst, .ctl,
    .in_valid  (in_valid && in_ready && !ctl.flush),
    .in_word   (in_data),
    .cfg,
    .out_valid (m_v),
    .mean_new  (m_mean),
    .var_new   (m_var),
    .weight_dly(m_w),
    .last_dly  (m_l)
  );

  // sideband delay line alongside the square root
  localparam int SqN = SqrtStages;
  logic signed [31:0] sw [SqN+1];
  logic signed [31:0] sm [SqN+1];
  logic [31:0]        sv [SqN+1];
  logic               sl [SqN+1];
  assign sw[0] = m_w;
  assign sm[0] = m_mean;
  assign sv[0] = m_var;
  assign sl[0] = m_l;
  for (genvar i = 0; i < SqN; i++) begin : g_sd
    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        sw[i+1] <= sw[i];
        sm[i+1] <= sm[i];
        sv[i+1] <= sv[i];
        sl[i+1] <= sl[i];
      end
    end
  end

  logic        r_v;
  logic [27:0] r_root;

  adam_sqrt u_sqrt (
    .clk, .rst, .ctl,
    .in_valid (m_v),
    .radicand ({m_var, 24'd0}),
    .out_valid(r_v),
    .root     (r_root)
  );

  // divisor setup stage 1: den and |m|
  logic               d1_v, d2_v;
  logic [28:0]        d1_den, d2_den;
  logic [31:0]        d1_mag;
  logic [55:0]        d2_num;
  logic               d1_ng, d2_ng;
  logic signed [31:0] d1_w, d1_m, d2_w, d2_m;
  logic [31:0]        d1_var, d2_var;
  logic               d1_l, d2_l;
  logic [24:0]        eps_eff;
  assign eps_eff = (cfg.epsilon == '0) ? 25'd1 : cfg.epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
      d2_v <= 1'b0;
    end else if (ctl.advance) begin
      d1_v <= r_v;
      d2_v <= d1_v;
    end
    if (ctl.advance) begin
      d1_den <= 29'(r_root) + 29'(eps_eff);
      d1_mag <= sm[SqN][31] ? 32'(-sm[SqN]) : sm[SqN];
      d1_ng  <= sm[SqN][31];
      d1_w   <= sw[SqN];
      d1_m   <= sm[SqN];
      d1_var <= sv[SqN];
      d1_l   <= sl[SqN];
      // stage 2: rounded dividend
      d2_num <= {d1_mag, 24'd0} + 56'(d1_den >> 1);
      d2_den <= d1_den;
      d2_ng  <= d1_ng;
      d2_w   <= d1_w;
      d2_m   <= d1_m;
      d2_var <= d1_var;
      d2_l   <= d1_l;
    end
  end

  logic               q_v;
  logic signed [31:0] q_ratio, q_w, q_m;
  logic [31:0]        q_var;
  logic               q_l;

  adam_divide u_div (
    .clk, .rst, .ctl,
    .in_valid (d2_v),
    .dividend (d2_num),
    .divisor  (d2_den),
    .neg_in   (d2_ng),
    .weight_in(d2_w),
    .mean_in  (d2_m),
    .var_in   (d2_var),
    .last_in  (d2_l),
    .out_valid(q_v),
    .ratio    (q_ratio),
    .weight_o (q_w),
    .mean_o   (q_m),
    .var_o    (q_var),
    .last_o   (q_l)
  );

  // scale stage: alpha * q
  logic               s_v;
  logic signed [63:0] s_prod;
  logic signed [31:0] s_w, s_m;
  logic [31:0]        s_var;
  logic               s_l;

  always_ff @(posedge clk) begin
    if (rst) s_v <= 1'b0;
    else if (ctl.advance) s_v <= q_v;
    if (ctl.advance) begin
      s_prod <= cfg.step_scale * q_ratio;
      s_w    <= q_w;
      s_m    <= q_m;
      s_var  <= q_var;
      s_l    <= q_l;
    end
  end

  // output stage: round, add, saturate
  logic signed [40:0] rnd;
  logic signed [41:0] psum;
  assign rnd  = 41'((s_prod + 64'sd8388608) >>> FracBits);
  assign psum = 42'(rnd) + 42'(s_w);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.advance) out_valid <= s_v;
    if (ctl.advance) begin
      if (psum > 42'sd2147483647) out_data.weight_out <= 32'h7fffffff;
      else if (psum < -42'sd2147483648) out_data.weight_out <= 32'h80000000;
      else out_data.weight_out <= psum[31:0];
      out_data.mean_out     <= s_m;
      out_data.variance_out <= s_var;
      out_data.last_out     <= s_l;
    end
  end

  // checks
  `ADAM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")
  `ADAM_ASSERT_NOW(a_ready, clk, rst, !out_valid, in_ready, "input blocked with empty output")
  `ADAM_ASSERT_NEXT(a_cfg, clk, rst, cfg_we && cfg_index == REG_EPSILON, cfg.epsilon == $past(cfg_data[24:0]), "epsilon write lost")
endmodule

// ----- design/adam_moments.sv -----
`timescale 1ns / 1ps
// moment update: four register stages, multipliers then sums then rounding
module adam_moments (
  input  logic                   clk,
  input  logic                   rst,
  input  adam_pkg::pipe_ctl_t    ctl,
  input  logic                   in_valid,
  input  adam_pkg::in_word_t     in_word,
  input  adam_pkg::cfg_t         cfg,
  output logic                   out_valid,
  output logic signed [31:0]     mean_new,
  output logic [31:0]            var_new,
  output logic signed [31:0]     weight_dly,
  output logic                   last_dly
);
  import adam_pkg::*;

  // stage a: products
  logic               va;
  logic signed [56:0] mb_a, gb_a;
  logic [63:0]        gsq_a;
  logic signed [31:0] w_a;
  logic               l_a;
  logic [31:0]        v_a;
  logic [24:0]        omb2_a;
  logic [23:0]        b2_a;
  logic [31:0]        gmag;
  logic [24:0]        omb1;

  assign gmag = in_word.gradient[31] ? 32'(-in_word.gradient) : in_word.gradient;
  assign omb1 = 25'h1000000 - {1'b0, cfg.decay_first};

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (ctl.advance) va <= in_valid;
    if (ctl.advance) begin
      mb_a   <= 57'(in_word.mean_in * $signed({1'b0, cfg.decay_first}));
      gb_a   <= 57'(in_word.gradient * $signed({1'b0, omb1}));
      gsq_a  <= gmag * gmag;
      w_a    <= in_word.weight_in;
      l_a    <= in_word.last_in;
      v_a    <= in_word.variance_in;
      omb2_a <= 25'h1000000 - {1'b0, cfg.decay_second};
      b2_a   <= cfg.decay_second;
    end
  end

  // stage b: mean sum, gsq round, v*b2
  logic               vb;
  logic signed [57:0] msum_b;
  logic [38:0]        gsq_b;
  logic [55:0]        vb2_b;
  logic [24:0]        omb2_b;
  logic signed [31:0] w_b;
  logic               l_b;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (ctl.advance) vb <= va;
    if (ctl.advance) begin
      msum_b <= 58'(mb_a) + 58'(gb_a) + 58'sd8388608;
      gsq_b  <= 39'((gsq_a + 64'd8388608) >> FracBits);
      vb2_b  <= v_a * b2_a;
      omb2_b <= omb2_a;
      w_b    <= w_a;
      l_b    <= l_a;
    end
  end

  // stage c: mean shift, gsq*(1-b2)
  logic               vc;
  logic signed [33:0] mr_c;
  logic [63:0]        gp_c;
  logic [55:0]        vb2_c;
  logic signed [31:0] w_c;
  logic               l_c;

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (ctl.advance) vc <= vb;
    if (ctl.advance) begin
      mr_c  <= 34'(msum_b >>> FracBits);
      gp_c  <= 64'(gsq_b) * 64'(omb2_b);
      vb2_c <= vb2_b;
      w_c   <= w_b;
      l_c   <= l_b;
    end
  end

  // stage d: variance sum and saturation
  logic [64:0] vs;
  logic [40:0] vr;
  assign vs = 65'(gp_c) + 65'(vb2_c) + 65'd8388608;
  assign vr = 41'(vs >> FracBits);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.advance) out_valid <= vc;
    if (ctl.advance) begin
      if (mr_c > 34'sd2147483647) mean_new <= 32'h7fffffff;
      else if (mr_c < -34'sd2147483648) mean_new <= 32'h80000000;
      else mean_new <= mr_c[31:0];
      var_new    <= (vr[40:32] != 9'd0) ? 32'hffffffff : vr[31:0];
      weight_dly <= w_c;
      last_dly   <= l_c;
    end
  end
endmodule

// ----- design/adam_sqrt.sv -----
`timescale 1ns / 1ps
// pipelined square root of v*2^24, one result bit per stage (28 stages)
module adam_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  adam_pkg::pipe_ctl_t ctl,
  input  logic                in_valid,
  input  logic [55:0]         radicand,
  output logic                out_valid,
  output logic [27:0]         root
);
  import adam_pkg::*;

  localparam int N = SqrtStages;

  logic [N:0]      vld;
  logic [55:0]     rem [N+1];
  logic [27:0]     res [N+1];

  assign vld[0] = in_valid;
  assign rem[0] = radicand;
  assign res[0] = '0;

  // restoring digit stages
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [57:0] trial;
    logic [57:0] r2;
    assign trial = {res[i], 2'b01} << (2 * (N - 1 - i));
    assign r2    = {2'b00, rem[i]};
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (ctl.advance) vld[i+1] <= vld[i];
      if (ctl.advance) begin
        if (r2 >= trial) begin
          rem[i+1] <= 56'(r2 - trial);
          res[i+1] <= {res[i][26:0], 1'b1};
        end else begin
          rem[i+1] <= rem[i];
          res[i+1] <= {res[i][26:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N];
endmodule

// ----- design/adam_divide.sv -----
`timescale 1ns / 1ps
// pipelined restoring divide of |m|*2^24 + den/2 by den, 56 quotient bits
module adam_divide (
  input  logic                clk,
  input  logic                rst,
  input  adam_pkg::pipe_ctl_t ctl,
  input  logic                in_valid,
  input  logic [55:0]         dividend,
  input  logic [28:0]         divisor,
  input  logic                neg_in,
  input  logic signed [31:0]  weight_in,
  input  logic signed [31:0]  mean_in,
  input  logic [31:0]         var_in,
  input  logic                last_in,
  output logic                out_valid,
  output logic signed [31:0]  ratio,
  output logic signed [31:0]  weight_o,
  output logic signed [31:0]  mean_o,
  output logic [31:0]         var_o,
  output logic                last_o
);
  import adam_pkg::*;

  localparam int N = 56;

  logic [N:0]         vld;
  logic [28:0]        rem [N+1];
  logic [55:0]        num [N+1];
  logic [28:0]        dv  [N+1];
  logic               ng  [N+1];
  logic signed [31:0] wp  [N+1];
  logic signed [31:0] mp  [N+1];
  logic [31:0]        vp  [N+1];
  logic               lp  [N+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign num[0] = dividend;
  assign dv[0]  = divisor;
  assign ng[0]  = neg_in;
  assign wp[0]  = weight_in;
  assign mp[0]  = mean_in;
  assign vp[0]  = var_in;
  assign lp[0]  = last_in;

  // one quotient bit per stage, quotient shifts into num
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [29:0] sh;
    assign sh = {rem[i], num[i][55]};
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (ctl.advance) vld[i+1] <= vld[i];
      if (ctl.advance) begin
        if (sh >= {1'b0, dv[i]}) begin
          rem[i+1] <= 29'(sh - {1'b0, dv[i]});
          num[i+1] <= {num[i][54:0], 1'b1};
        end else begin
          rem[i+1] <= sh[28:0];
          num[i+1] <= {num[i][54:0], 1'b0};
        end
        dv[i+1] <= dv[i];
        ng[i+1] <= ng[i];
        wp[i+1] <= wp[i];
        mp[i+1] <= mp[i];
        vp[i+1] <= vp[i];
        lp[i+1] <= lp[i];
      end
    end
  end

  // sign and saturation
  logic [55:0] q;
  assign q = num[N];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.advance) out_valid <= vld[N];
    if (ctl.advance) begin
      if (ng[N]) ratio <= (q > 56'h80000000) ? 32'h80000000 : 32'(-q);
      else       ratio <= (q > 56'h7fffffff) ? 32'h7fffffff : q[31:0];
      weight_o <= wp[N];
      mean_o   <= mp[N];
      var_o    <= vp[N];
      last_o   <= lp[N];
    end
  end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import adam_pkg::*;

  localparam int Latency = 92;
  localparam int StallLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // update coefficients as the scoreboard sees them
  logic signed [31:0] alpha_q = 32'sd0;
  logic [23:0] beta1_q = 24'd15099494;
  logic [23:0] beta2_q = 24'd16760438;
  logic [24:0] eps_q = 25'd1;

  int errors = 0;
  bit calm = 1'b0;
  bit sending = 1'b1;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  adam_parameter_update dut (.*);

  // Q8.24 rounding, floor((x + 2^23) / 2^24)
  function automatic logic signed [127:0] round_q24(logic signed [127:0] x);
    return (x + 128'sd8388608) >>> 24;
  endfunction

  function automatic logic signed [127:0] clip_s32(logic signed [127:0] x);
    if (x > 128'sd2147483647) return 128'sd2147483647;
    if (x < -128'sd2147483648) return -128'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one adam step for a single parameter word
  function automatic out_word_t adam_update(in_word_t w);
    out_word_t o;
    logic signed [127:0] p, g, m, mn, q, pn;
    logic [127:0] mag_g, gsq, vs, vn, root, den, mag_m, qmag;
    p = w.weight_in;
    g = w.gradient;
    m = w.mean_in;
    mn = clip_s32(round_q24(m * $signed({104'd0, beta1_q})
         + g * $signed(128'd16777216 - beta1_q)));
    mag_g = (g < 0) ? -g : g;
    gsq = (mag_g * mag_g + 128'd8388608) >> 24;
    vs = w.variance_in * beta2_q + gsq * (128'd16777216 - beta2_q);
    vn = (vs + 128'd8388608) >> 24;
    if (vn > 128'hFFFFFFFF) vn = 128'hFFFFFFFF;
    root = int_sqrt(vn[63:0] << 24);
    den = root + ((eps_q == 0) ? 128'd1 : eps_q);
    mag_m = (mn < 0) ? -mn : mn;
    qmag = ((mag_m << 24) + (den >> 1)) / den;
    if (mn < 0) q = (qmag > 128'h80000000) ? -128'sd2147483648 : -$signed(qmag);
    else q = (qmag > 128'h7FFFFFFF) ? 128'sd2147483647 : $signed(qmag);
    pn = clip_s32(p + round_q24($signed({{96{alpha_q[31]}}, alpha_q}) * q));
    o.weight_out = pn[31:0];
    o.mean_out = mn[31:0];
    o.variance_out = vn[31:0];
    o.last_out = w.last_in;
    return o;
  endfunction

  class update_scoreboard;
    out_word_t pending[$];

    function void note_word(out_word_t e);
      pending.push_back(e);
    endfunction

    function int check_word(out_word_t a);
      out_word_t e;
      int bad;
      bad = 0;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", a);
        return 1;
      end
      e = pending.pop_front();
      if (a.weight_out !== e.weight_out) begin
        $error("weight_out expected %h actual %h", e.weight_out, a.weight_out);
        bad = 1;
      end
      if (a.mean_out !== e.mean_out) begin
        $error("mean_out expected %h actual %h", e.mean_out, a.mean_out);
        bad = 1;
      end
      if (a.variance_out !== e.variance_out) begin
        $error("variance_out expected %h actual %h", e.variance_out, a.variance_out);
        bad = 1;
      end
      if (a.last_out !== e.last_out) begin
        $error("last_out expected %b actual %b", e.last_out, a.last_out);
        bad = 1;
      end
      return bad;
    endfunction
  endclass

  update_scoreboard sb = new();

  // sample accepted words on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(adam_update(in_data));
      if (out_valid && out_ready) errors += sb.check_word(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else if (sending || sb.pending.size() != 0) idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STEP_SCALE: alpha_q = val;
      REG_DECAY_FIRST: beta1_q = val[23:0];
      REG_DECAY_SECOND: beta2_q = val[23:0];
      default: eps_q = val[24:0];
    endcase
  endtask

  task automatic send_word(in_word_t w);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (Latency + 8) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return $urandom_range(16777216 * 2);
      4: return -$urandom_range(16777216 * 2);
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.weight_in = rand_value();
    w.gradient = ($urandom_range(3) == 0) ? rand_value() : ($urandom() >>> 10);
    w.mean_in = rand_value();
    w.variance_in = rand_value();
    w.last_in = $urandom_range(1);
    return w;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_word(rand_word());
    drain();
  endtask

  initial begin
    logic [31:0] edge_vals[4];
    in_word_t w;
    edge_vals = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words at the field extremes with reset coefficients
    for (int i = 0; i < 16; i++) begin
      w.weight_in = edge_vals[i % 4];
      w.gradient = edge_vals[(i / 4) % 4];
      w.mean_in = edge_vals[(i + 1) % 4];
      w.variance_in = edge_vals[(i + 2) % 4];
      w.last_in = i[0];
      send_word(w);
    end
    drain();

    // zero decay replaces the moments, zero and large epsilon, big ratio
    write_reg(REG_STEP_SCALE, 32'h80000000);
    write_reg(REG_DECAY_FIRST, 32'd0);
    write_reg(REG_DECAY_SECOND, 32'd0);
    write_reg(REG_EPSILON, 32'd0);
    send_word('{32'h01000000, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1});
    send_word('{32'h80000000, 32'h00000001, 32'h0, 32'h0, 1'b0});
    send_word('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1});
    drain();
    write_reg(REG_EPSILON, 32'h1FFFFFF);
    write_reg(REG_STEP_SCALE, 32'h7FFFFFFF);
    write_reg(REG_DECAY_FIRST, 32'hFFFFFF);
    write_reg(REG_DECAY_SECOND, 32'hFFFFFF);
    send_word('{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b0});
    send_word('{32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b1});
    drain();

    // random coefficient settings, one calm phase with no idling
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_STEP_SCALE, (ph == 1) ? 32'h80000000 : -$urandom_range(1 << 20));
      write_reg(REG_DECAY_FIRST, (ph == 2) ? 32'd0 : $urandom_range(24'hFFFFFF));
      write_reg(REG_DECAY_SECOND, (ph == 3) ? 32'hFFFFFF : $urandom_range(24'hFFFFFF));
      write_reg(REG_EPSILON, (ph == 4) ? 32'd1 : $urandom_range(25'h1FFFFFF));
      calm = (ph == 5);
      random_phase(315);
    end
    sending = 1'b0;

    if (errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
